[rtl/tdpt_pkg.sv]
// Package for the trial-division prime test.
// Holds the controller state type and the command and status structs
// shared by tdpt_ctrl, tdpt_dpath and the top level. No dependencies.
package tdpt_pkg;

  // Width of the candidate field on the input channel.
  localparam int unsigned CandW = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_EVAL
  } tdpt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the candidate and set the divisor to three
    logic start_div;   // begin a new division of the candidate by the divisor
    logic div_step;    // one restoring-division step
    logic next_div;    // advance the divisor to the next odd value
    logic set_result;  // write the result register
    logic result_val;  // value written on set_result
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic negative;    // sign bit of the captured candidate
    logic le_one;      // candidate is zero or one
    logic is_two;      // candidate equals two
    logic is_even;     // candidate is even
    logic div_last;    // the current step is the final division step
    logic d_gt_q;      // divisor exceeds quotient, no more divisors to try
    logic rem_zero;    // remainder of the last division is zero
  } tdpt_status_t;

endpackage

[rtl/tdpt_ctrl.sv]
// Controller state machine of the trial-division prime test.
// Sequences classification, iterative division and result transfer.
// Depends on tdpt_pkg.
module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  tdpt_status_t status_i,
  output tdpt_cmd_t    cmd_o
);

  tdpt_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result register may be written when it is empty or being taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status_i.negative || status_i.le_one || status_i.is_two ||
            status_i.is_even) begin
          if (out_free) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_val = status_i.is_two && !status_i.negative;
            out_valid_d      = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.d_gt_q || status_i.rem_zero) begin
          if (out_free) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result_val = status_i.d_gt_q;
            out_valid_d      = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          cmd_o.next_div  = 1'b1;
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/tdpt_dpath.sv]
// Datapath of the trial-division prime test: candidate and divisor
// registers, a one-bit-per-cycle restoring divider and the result register.
// Depends on tdpt_pkg.
module tdpt_dpath
  import tdpt_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [CandW-1:0] candidate_i,
  input  tdpt_cmd_t               cmd_i,
  output tdpt_status_t            status_o,
  output logic                    prime_flag_o
);

  localparam int unsigned NB   = NUMBER_BITS;
  localparam int unsigned CntW = $clog2(NB);

  logic [NB-1:0]   cand_n;
  logic [NB-1:0]   n_q;
  logic [NB-1:0]   d_q;
  logic [NB-1:0]   rem_q;
  logic [NB-1:0]   quo_q;
  logic [CntW-1:0] cnt_q;
  logic            prime_q;

  logic [NB:0]     rem_sh;
  logic [NB:0]     diff;
  logic            fits;

  // Only the low NUMBER_BITS bits of the candidate take part.
  if (NB <= CandW) begin : g_trunc
    assign cand_n = candidate_i[NB-1:0];
  end else begin : g_ext
    assign cand_n = {{(NB - CandW){1'b0}}, candidate_i};
  end

  // Restoring division: bring down the next dividend bit and subtract
  // the divisor when it fits.
  assign rem_sh = {rem_q, quo_q[NB-1]};
  assign diff   = rem_sh - {1'b0, d_q};
  assign fits   = !diff[NB];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= cand_n;
      d_q <= NB'(3);
    end else if (cmd_i.next_div) begin
      d_q <= d_q + NB'(2);
    end
    if (cmd_i.start_div) begin
      rem_q <= '0;
      quo_q <= n_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? diff[NB-1:0] : rem_sh[NB-1:0];
      quo_q <= {quo_q[NB-2:0], fits};
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= 1'b0;
    end else if (cmd_i.set_result) begin
      prime_q <= cmd_i.result_val;
    end
  end

  assign status_o.negative = n_q[NB-1];
  assign status_o.le_one   = (n_q[NB-1:1] == '0);
  assign status_o.is_two   = (n_q == NB'(2));
  assign status_o.is_even  = !n_q[0];
  assign status_o.div_last = (cnt_q == CntW'(NB - 1));
  assign status_o.d_gt_q   = (d_q > quo_q);
  assign status_o.rem_zero = (rem_q == '0);

  assign prime_flag_o = prime_q;

endmodule

[rtl/trial_division_prime_test.sv]
// Top level of the trial-division prime test.
// Joins the controller tdpt_ctrl and the datapath tdpt_dpath.
// Depends on tdpt_pkg.
//
//   Channel | Direction | Payload          | Handshake
//   --------+-----------+------------------+--------------------------
//   input   | in        | candidate_i [32] | in_valid_i / in_stall_o
//   output  | out       | prime_flag_o [1] | out_valid_o / out_stall_i
//
// One item is tested at a time. Values that are negative, zero, one, two
// or even are settled in the classify state that follows the transfer in,
// once the result register is free. Odd candidates go through odd
// divisors 3, 5, 7, ... up to the square root; each trial takes
// NUMBER_BITS steps of the one-bit-per-cycle restoring divider plus one
// evaluation step. A 31-bit prime takes about 23170 trials.
// Reset clears the state machine and the result valid flag. The result
// sits in an output register, so a new candidate may transfer in while the
// previous result is still stalled; the block then waits at the end of the
// new test until that result has been taken.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [CandW-1:0] candidate_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    prime_flag_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  // The state machine decides what the datapath does each cycle.
  tdpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the candidate, the divisor and the divider.
  tdpt_dpath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .candidate_i  (candidate_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .prime_flag_o (prime_flag_o)
  );

endmodule
